// ----- rtl/tes_pkg.sv -----
// Package with command modes and result kinds of the timer expiry scheduler.
package tes_pkg;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;
  localparam logic [1:0] MODE_PURGE  = 2'd3;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_CANCEL = 3'd1;
  localparam logic [2:0] KIND_FIRED  = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_PURGE  = 3'd4;

  localparam logic [32:0] NT_EMPTY = 33'h1_FFFF_FFFF;
  localparam logic [32:0] NT_SAT   = 33'h0_FFFF_FFFF;

  typedef logic [63:0] tes_time_t;

endpackage

// ----- rtl/tes_ram.sv -----
// Generic single write port RAM with a registered read port.
module tes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/timer_expiry_scheduler.sv -----
// Top level of the timer expiry scheduler: a table of one-shot and periodic timers.
//
// The block keeps up to TIMER_SLOTS timers. Each command transfer (mode) is one of
// tick, add, cancel or purge. Add, cancel and purge give one result; a tick gives one
// fired result per live timer that falls due, in order of expiry (lower slot first on a
// tie), and then a tick-done result, the last one flagged by last. Every result carries
// next_timeout, the time in milliseconds to the earliest stored expiry (0 when due, -1
// when the table is empty, saturated at 2^32-1). The timer ids, expiries and periods
// live in three small RAMs that are read one slot per cycle by a shared scan unit,
// which finds the earliest expiry and the earliest due timer in a single pass; valid and
// cancel marks are flip-flops. A command goes through an action step, a scan of all
// slots, evaluation and result hand-off; a tick scans again after each timer that
// fires, and also after each cancelled timer that falls due and is dropped. in_stall
// stays high while a command is being worked on; the output register lets the block
// go on to its next step while a result waits.
module timer_expiry_scheduler
  import tes_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] delay,
  input  logic [31:0] period,
  input  logic [31:0] target_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] result_id,
  output logic        ok,
  output logic signed [32:0] next_timeout,
  output logic        last
);

  localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] SCAN_END = CW'(TIMER_SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACT  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]  state;
  logic [1:0]  cmd_mode;
  logic [31:0] cmd_delay;
  logic [31:0] cmd_period;
  logic [31:0] cmd_target;
  tes_time_t   cur_time;
  logic [31:0] id_counter;

  logic [TIMER_SLOTS-1:0] slot_valid;
  logic [TIMER_SLOTS-1:0] slot_cancelled;
  logic [TIMER_SLOTS-1:0] match;

  logic [CW-1:0] scan_cnt;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] raddr;

  logic        any_valid;
  tes_time_t   best;
  logic        pick_found;
  logic [AW-1:0] pick_idx;
  tes_time_t   pick_exp;
  logic [31:0] pick_id;
  logic [31:0] pick_per;
  logic        pick_canc;
  logic        already;

  logic        pend;
  logic [31:0] pend_id;

  logic [2:0]  res_kind;
  logic [31:0] res_id;
  logic        res_ok;
  logic        res_last;
  logic [32:0] nt;

  logic [31:0] rd_id;
  tes_time_t   rd_exp;
  logic [31:0] rd_per;

  logic          free_found;
  logic [AW-1:0] free_idx;

  logic          add_we;
  logic          exp_we;
  logic [AW-1:0] exp_waddr;
  tes_time_t     exp_wdata;

  logic          out_load;
  logic [32:0]   nt_next;
  tes_time_t     diff;
  logic          rd_valid_slot;
  logic          rd_hit;

  // Lowest free slot for an add.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  assign raddr = (scan_cnt < SCAN_END) ? scan_cnt[AW-1:0] : '0;

  assign add_we = (state == S_ACT) && (cmd_mode == MODE_ADD) && free_found;

  // The expiry RAM is written on add and on a periodic reload.
  always_comb begin
    exp_we    = 1'b0;
    exp_waddr = free_idx;
    exp_wdata = cur_time + tes_time_t'(cmd_delay);
    if (add_we) begin
      exp_we = 1'b1;
    end else if (state == S_PICK && pick_found && !pick_canc && pick_per != '0) begin
      exp_we    = 1'b1;
      exp_waddr = pick_idx;
      exp_wdata = cur_time + tes_time_t'(pick_per);
    end
  end

  tes_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS), .AW(AW)) u_id_ram (
    .clk   (clk),
    .we    (add_we),
    .waddr (free_idx),
    .wdata (id_counter),
    .raddr (raddr),
    .rdata (rd_id)
  );

  tes_ram #(.WIDTH(64), .DEPTH(TIMER_SLOTS), .AW(AW)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_waddr),
    .wdata (exp_wdata),
    .raddr (raddr),
    .rdata (rd_exp)
  );

  tes_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS), .AW(AW)) u_per_ram (
    .clk   (clk),
    .we    (add_we),
    .waddr (free_idx),
    .wdata (cmd_period),
    .raddr (raddr),
    .rdata (rd_per)
  );

  assign rd_valid_slot = slot_valid[rd_idx];
  assign rd_hit        = rd_valid_slot && (rd_id == cmd_target);

  // Time to the earliest expiry, from the scan result.
  assign diff = best - cur_time;
  always_comb begin
    if (!any_valid) begin
      nt_next = NT_EMPTY;
    end else if (best <= cur_time) begin
      nt_next = '0;
    end else if (diff[63:32] != '0) begin
      nt_next = NT_SAT;
    end else begin
      nt_next = {1'b0, diff[31:0]};
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cur_time       <= '0;
      id_counter     <= '0;
      slot_valid     <= '0;
      slot_cancelled <= '0;
      pend           <= 1'b0;
      out_valid      <= 1'b0;
      scan_cnt       <= '0;
      rd_vld         <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid    <= 1'b1;
        kind         <= res_kind;
        result_id    <= res_id;
        ok           <= res_ok;
        next_timeout <= nt;
        last         <= res_last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_mode   <= mode;
            cmd_delay  <= delay;
            cmd_period <= period;
            cmd_target <= target_id;
            state      <= S_ACT;
          end
        end
        S_ACT: begin
          unique case (cmd_mode)
            MODE_ADD: begin
              res_id <= id_counter;
              res_ok <= free_found;
              if (free_found) begin
                slot_valid[free_idx]     <= 1'b1;
                slot_cancelled[free_idx] <= 1'b0;
                id_counter               <= id_counter + 32'd1;
              end
            end
            MODE_PURGE: begin
              slot_valid     <= slot_valid & ~slot_cancelled;
              slot_cancelled <= '0;
            end
            MODE_TICK: begin
              cur_time <= cur_time + 64'd1;
            end
            default: begin
            end
          endcase
          scan_cnt   <= '0;
          rd_vld     <= 1'b0;
          any_valid  <= 1'b0;
          pick_found <= 1'b0;
          already    <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          // One slot a cycle: the RAM data of slot rd_idx arrives now.
          rd_vld <= (scan_cnt < SCAN_END);
          rd_idx <= raddr;
          if (scan_cnt != SCAN_END) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
          if (rd_vld) begin
            if (rd_valid_slot && (!any_valid || rd_exp < best)) begin
              best      <= rd_exp;
              any_valid <= 1'b1;
            end
            if (rd_valid_slot && rd_exp <= cur_time && (!pick_found || rd_exp < pick_exp)) begin
              pick_found <= 1'b1;
              pick_idx   <= rd_idx;
              pick_exp   <= rd_exp;
              pick_id    <= rd_id;
              pick_per   <= rd_per;
              pick_canc  <= slot_cancelled[rd_idx];
            end
            match[rd_idx] <= rd_hit;
            if (rd_hit && slot_cancelled[rd_idx]) begin
              already <= 1'b1;
            end
          end
          if (scan_cnt == SCAN_END) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          nt <= nt_next;
          unique case (cmd_mode)
            MODE_ADD: begin
              res_kind <= KIND_ADD;
              res_last <= 1'b1;
              state    <= S_EMIT;
            end
            MODE_CANCEL: begin
              if (!already) begin
                slot_cancelled <= slot_cancelled | match;
              end
              res_kind <= KIND_CANCEL;
              res_id   <= cmd_target;
              res_ok   <= !already;
              res_last <= 1'b1;
              state    <= S_EMIT;
            end
            MODE_PURGE: begin
              res_kind <= KIND_PURGE;
              res_id   <= '0;
              res_ok   <= 1'b0;
              res_last <= 1'b1;
              state    <= S_EMIT;
            end
            default: begin
              // A fired timer is reported once the state after its reload is scanned.
              if (pend) begin
                pend     <= 1'b0;
                res_kind <= KIND_FIRED;
                res_id   <= pend_id;
                res_ok   <= 1'b0;
                res_last <= 1'b0;
                state    <= S_EMIT;
              end else begin
                state <= S_PICK;
              end
            end
          endcase
        end
        S_PICK: begin
          if (pick_found) begin
            if (pick_canc) begin
              slot_valid[pick_idx]     <= 1'b0;
              slot_cancelled[pick_idx] <= 1'b0;
            end else begin
              if (pick_per == '0) begin
                slot_valid[pick_idx] <= 1'b0;
              end
              pend    <= 1'b1;
              pend_id <= pick_id;
            end
            scan_cnt   <= '0;
            rd_vld     <= 1'b0;
            any_valid  <= 1'b0;
            pick_found <= 1'b0;
            already    <= 1'b0;
            state      <= S_SCAN;
          end else begin
            res_kind <= KIND_TICK;
            res_id   <= '0;
            res_ok   <= 1'b0;
            res_last <= 1'b1;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state <= res_last ? S_IDLE : S_PICK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cancel_only_valid: assert property (@(posedge clk) disable iff (rst)
    (slot_cancelled & ~slot_valid) == '0)
    else $error("cancel mark on an empty slot");

  a_accept_to_act: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_ACT))
    else $error("accepted command did not start");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_cnt == SCAN_END) |=> (state == S_EVAL))
    else $error("scan did not finish");

  a_id_advance: assert property (@(posedge clk) disable iff (rst)
    add_we |=> (id_counter == $past(id_counter) + 32'd1))
    else $error("id counter did not advance on add");

  a_pend_tick: assert property (@(posedge clk) disable iff (rst)
    pend |-> (cmd_mode == MODE_TICK))
    else $error("pending fired result outside a tick");

endmodule
